// File: sv/nlep_pkg.sv
// ----------------------------------------------------------------------------
// nlep_pkg
// Shared types and constants of the numeric line entry parser.
// ----------------------------------------------------------------------------
package nlep_pkg;

   localparam logic [7:0]  CHAR_CR   = 8'd13;
   localparam logic [7:0]  CHAR_BS   = 8'd8;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
   localparam int          DIV10_SHR = 35;

   typedef enum logic [1:0] {
      OP_DIGIT,
      OP_BACK,
      OP_ENTER
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       hex;
      logic [3:0] digit;
      logic [7:0] ch;
   } cmd_type;

   typedef enum logic {
      KIND_ECHO   = 1'b0,
      KIND_NUMBER = 1'b1
   } kind_type;

endpackage

// File: sv/nlep_front.sv
// ----------------------------------------------------------------------------
// nlep_front
// Classifies a received character into a digit, backspace or enter request
// and drops everything else.
// ----------------------------------------------------------------------------
module nlep_front (
   input  logic             req_push,
   input  logic [7:0]       req_rx_char,
   input  logic             hex_mode,
   input  logic             cmd_full,
   output logic             cmd_push,
   output nlep_pkg::cmd_type cmd_data
);
   import nlep_pkg::*;

   logic       is_dec;
   logic       is_upper;
   logic       is_lower;
   logic       is_digit;
   logic [7:0] offs;

   always_comb begin
      is_dec   = (req_rx_char >= 8'h30) && (req_rx_char <= 8'h39);
      is_upper = hex_mode && (req_rx_char >= 8'h41) && (req_rx_char <= 8'h46);
      is_lower = hex_mode && (req_rx_char >= 8'h61) && (req_rx_char <= 8'h66);
      is_digit = is_dec || is_upper || is_lower;
      if (is_dec) begin
         offs = req_rx_char - 8'h30;
      end else if (is_upper) begin
         offs = req_rx_char - 8'h37;
      end else begin
         offs = req_rx_char - 8'h57;
      end

      cmd_data.hex   = hex_mode;
      cmd_data.digit = offs[3:0];
      cmd_data.ch    = req_rx_char;
      priority if (req_rx_char == CHAR_CR) begin
         cmd_data.op = OP_ENTER;
      end else if (req_rx_char == CHAR_BS) begin
         cmd_data.op = OP_BACK;
      end else begin
         cmd_data.op = OP_DIGIT;
      end

      cmd_push = req_push && !cmd_full &&
                 (is_digit || (req_rx_char == CHAR_CR) || (req_rx_char == CHAR_BS));
   end

endmodule

// File: sv/nlep_cmd_queue.sv
// ----------------------------------------------------------------------------
// nlep_cmd_queue
// Two-entry request queue between the classifier and the execution side.
// ----------------------------------------------------------------------------
module nlep_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nlep_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output nlep_pkg::cmd_type pop_data,
   output logic              empty
);
   import nlep_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/nlep_back.sv
// ----------------------------------------------------------------------------
// nlep_back
// Executes queued requests on the accumulator and digit count and holds the
// results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module nlep_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  nlep_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_echo_char,
   output logic [31:0]       rsp_number_value
);
   import nlep_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [31:0] value;
   } rsp_type;

   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic [15:0] count_ff;
   logic [15:0] count_in;
   rsp_type     buf_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  fill_ff;
   logic [1:0]  fill_in;
   logic        res_push;
   logic        res_pop;
   rsp_type     res_data;
   logic [63:0] prod;
   logic [31:0] quot10;
   logic [31:0] times_r;

   always_comb begin
      prod    = acc_ff * DIV10_MUL;
      quot10  = {3'b000, prod[63:DIV10_SHR]};
      times_r = cmd_data.hex ? {acc_ff[27:0], 4'b0000}
                             : ({acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0});

      cmd_pop  = !cmd_empty && (fill_ff != 2'd2);
      acc_in   = acc_ff;
      count_in = count_ff;
      res_push = 1'b0;
      res_data.kind  = KIND_ECHO;
      res_data.ch    = cmd_data.ch;
      res_data.value = 32'd0;

      if (cmd_pop) begin
         unique case (cmd_data.op)
            OP_DIGIT: begin
               acc_in   = times_r + {28'd0, cmd_data.digit};
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
               res_push = 1'b1;
            end
            OP_BACK: begin
               if (count_ff != 16'd0) begin
                  acc_in   = cmd_data.hex ? {4'b0000, acc_ff[31:4]} : quot10;
                  count_in = count_ff - 16'd1;
                  res_push = 1'b1;
               end
            end
            OP_ENTER: begin
               acc_in         = 32'd0;
               count_in       = 16'd0;
               res_push       = 1'b1;
               res_data.kind  = KIND_NUMBER;
               res_data.ch    = 8'd0;
               res_data.value = acc_ff;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      rsp_empty        = (fill_ff == 2'd0);
      res_pop          = rsp_pop && !rsp_empty;
      rsp_result_kind  = buf_ff[rd_ptr_ff].kind;
      rsp_echo_char    = buf_ff[rd_ptr_ff].ch;
      rsp_number_value = buf_ff[rd_ptr_ff].value;
      wr_ptr_in = res_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = res_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, res_push} - {1'b0, res_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 32'd0;
         count_ff  <= 16'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         acc_ff    <= acc_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         buf_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

// File: sv/numeric_line_entry_parser.sv
// ----------------------------------------------------------------------------
// numeric_line_entry_parser
// Builds an unsigned 32-bit number from received characters in decimal or
// hex entry mode, echoing digits and backspaces and returning the number on
// carriage return.
// ----------------------------------------------------------------------------
// One character is taken per cycle while req_full is low. A request passes
// the classifier, waits in a two-entry request queue and is executed by the
// accumulator unit (a shift-add for the radix multiply, a 32x32 reciprocal
// multiply for the divide by ten), whose result goes into a two-entry output
// buffer. With pop held high, one request and one result move every cycle.
// csr_ready is always high; write hex_mode only while no request is in flight.
module numeric_line_entry_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_echo_char,
   output logic [31:0] rsp_number_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hex_mode
);
   import nlep_pkg::*;

   logic    hex_mode_ff;
   logic    hex_mode_in;
   logic    cmd_push;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_in_data;
   cmd_type cmd_out_data;

   assign csr_ready   = 1'b1;
   assign hex_mode_in = (csr_valid && csr_ready) ? csr_hex_mode : hex_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_mode_ff <= 1'b0;
      end else begin
         hex_mode_ff <= hex_mode_in;
      end
   end

   nlep_front u_front (
      .req_push    (req_push),
      .req_rx_char (req_rx_char),
      .hex_mode    (hex_mode_ff),
      .cmd_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data)
   );

   nlep_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   nlep_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_data         (cmd_out_data),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_echo_char    (rsp_echo_char),
      .rsp_number_value (rsp_number_value)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("request queue popped while empty");

   a_number_no_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind) |-> (rsp_echo_char == 8'd0))
      else $error("number result carries an echo character");

   a_echo_no_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_result_kind) |-> (rsp_number_value == 32'd0))
      else $error("echo result carries a number");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !req_full)
      else $error("request pushed into full queue");

endmodule

// File: verif/numeric_line_entry_parser_tb.sv
// ----------------------------------------------------------------------------
// numeric_line_entry_parser_tb
// Self-checking bench for the numeric line entry parser. A directed table
// covers reset state, field extremes, ignored characters, backspace on an
// empty entry, hex letters of both cases and a radix change mid-entry.
// Random phases then send mostly well-formed entries with noise, in both radix
// settings, with and without random stalls on both queue interfaces. Results
// are checked against a cycle-free accumulator model or a row's typed result.
// ----------------------------------------------------------------------------
module numeric_line_entry_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nlep_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_SETTLE  = 6;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int PHASE_ITEMS  = 125;
   localparam int NUM_PHASES   = 6;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UF = 8'h46;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LF = 8'h66;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  echo;
      logic [31:0] value;
   } line_result_type;

   typedef enum logic {
      ROW_CHAR,
      ROW_HEX_MODE
   } row_op_type;

   typedef struct packed {
      row_op_type      op;
      logic [7:0]      data;
      logic            typed;
      line_result_type res;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   localparam line_result_type NO_RES = '{KIND_ECHO, 8'h00, 32'h0};

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CHAR,     CHAR_CR, 1'b1, '{KIND_NUMBER, 8'h00, 32'h0}},
      '{ROW_CHAR,     CHAR_BS, 1'b0, NO_RES},
      '{ROW_CHAR,     8'h00,   1'b0, NO_RES},
      '{ROW_CHAR,     8'hFF,   1'b0, NO_RES},
      '{ROW_CHAR,     CH_9,    1'b1, '{KIND_ECHO, CH_9, 32'h0}},
      '{ROW_CHAR,     CH_LA,   1'b0, NO_RES},
      '{ROW_CHAR,     8'h3A,   1'b0, NO_RES},
      '{ROW_CHAR,     CHAR_BS, 1'b1, '{KIND_ECHO, CHAR_BS, 32'h0}},
      '{ROW_CHAR,     CH_0,    1'b1, '{KIND_ECHO, CH_0, 32'h0}},
      '{ROW_CHAR,     CHAR_CR, 1'b1, '{KIND_NUMBER, 8'h00, 32'h0}},
      '{ROW_HEX_MODE, 8'h01,   1'b0, NO_RES},
      '{ROW_CHAR,     CH_LF,   1'b1, '{KIND_ECHO, CH_LF, 32'h0}},
      '{ROW_CHAR,     CH_UA,   1'b1, '{KIND_ECHO, CH_UA, 32'h0}},
      '{ROW_CHAR,     CH_UF,   1'b1, '{KIND_ECHO, CH_UF, 32'h0}},
      '{ROW_CHAR,     CH_LA,   1'b1, '{KIND_ECHO, CH_LA, 32'h0}},
      '{ROW_CHAR,     CH_0,    1'b1, '{KIND_ECHO, CH_0, 32'h0}},
      '{ROW_CHAR,     CH_9,    1'b1, '{KIND_ECHO, CH_9, 32'h0}},
      '{ROW_CHAR,     8'h47,   1'b0, NO_RES},
      '{ROW_CHAR,     CHAR_CR, 1'b1, '{KIND_NUMBER, 8'h00, 32'h00FA_FA09}},
      '{ROW_CHAR,     CH_UF,   1'b0, NO_RES},
      '{ROW_HEX_MODE, 8'h00,   1'b0, NO_RES},
      '{ROW_CHAR,     8'h37,   1'b0, NO_RES},
      '{ROW_CHAR,     CHAR_BS, 1'b0, NO_RES},
      '{ROW_CHAR,     CHAR_CR, 1'b0, NO_RES}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_char = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_echo_char;
   logic [31:0] rsp_number_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_hex_mode = 1'b0;

   // model state and config copy
   logic        model_hex;
   logic [31:0] model_acc;
   logic [15:0] model_digits;

   line_result_type pending_results [$];
   line_result_type typed_result;
   logic            typed_valid = 1'b0;
   logic            stall_on = 1'b1;
   logic            cur_hex = 1'b0;
   int              fail_count = 0;
   int              sent_items = 0;
   int              cycle_count = 0;

   numeric_line_entry_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_char      (req_rx_char),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_echo_char    (rsp_echo_char),
      .rsp_number_value (rsp_number_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_hex_mode     (csr_hex_mode)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Updates the accumulator model for one character; returns 1 when it echoes
   // or finishes a number.
   function automatic logic predict_char(input logic [7:0] c, output line_result_type r);
      logic [31:0] radix;
      logic [7:0]  d;
      logic        is_digit;
      radix = model_hex ? 32'd16 : 32'd10;
      r = '{KIND_ECHO, c, 32'h0};
      if (c == CHAR_CR) begin
         r = '{KIND_NUMBER, 8'h00, model_acc};
         model_acc = '0;
         model_digits = '0;
         return 1'b1;
      end
      is_digit = 1'b1;
      d = 8'h00;
      if (c >= CH_0 && c <= CH_9)
         d = c - CH_0;
      else if (model_hex && c >= CH_UA && c <= CH_UF)
         d = c - CH_UA + 8'd10;
      else if (model_hex && c >= CH_LA && c <= CH_LF)
         d = c - CH_LA + 8'd10;
      else
         is_digit = 1'b0;
      if (is_digit) begin
         model_acc = model_acc * radix + {24'h0, d};
         if (model_digits != COUNT_MAX)
            model_digits = model_digits + 16'd1;
         return 1'b1;
      end
      if (c == CHAR_BS && model_digits != 16'd0) begin
         model_acc = model_acc / radix;
         model_digits = model_digits - 16'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] pick_digit(input logic hex);
      int idx;
      if (!hex)
         return CH_0 + 8'($urandom_range(0, 9));
      idx = $urandom_range(0, 21);
      if (idx < 10)
         return CH_0 + 8'(idx);
      if (idx < 16)
         return CH_UA + 8'(idx - 10);
      return CH_LA + 8'(idx - 16);
   endfunction

   // monitor: checks popped results, predicts accepted requests
   always @(posedge clock) begin
      line_result_type got;
      line_result_type want;
      line_result_type pred;
      logic            has;
      if (reset) begin
         model_hex    = 1'b0;
         model_acc    = '0;
         model_digits = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{kind_type'(rsp_result_kind), rsp_echo_char, rsp_number_value};
            if (pending_results.size() == 0) begin
               $error("unexpected result: kind %0d echo 0x%02h value 0x%08h",
                      got.kind, got.echo, got.value);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind) begin
                  $error("rsp_result_kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.echo !== want.echo) begin
                  $error("rsp_echo_char: expected 0x%02h, got 0x%02h", want.echo, got.echo);
                  fail_count++;
               end
               if (got.value !== want.value) begin
                  $error("rsp_number_value: expected 0x%08h, got 0x%08h",
                         want.value, got.value);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            has = predict_char(req_rx_char, pred);
            sent_items++;
            if (typed_valid)
               pending_results.push_back(typed_result);
            else if (has)
               pending_results.push_back(pred);
         end
         if (csr_valid && csr_ready)
            model_hex = csr_hex_mode;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = stall_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_rx_char <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_hex_mode(input logic m);
      csr_valid    <= 1'b1;
      csr_hex_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_hex = m;
   endtask

   task automatic send_random_entry();
      int         len;
      int         roll;
      logic [7:0] c;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 68)
            c = pick_digit(cur_hex);
         else if (roll < 83)
            c = CHAR_BS;
         else if (roll < 90)
            c = pick_digit(1'b1);
         else if (roll < 94) begin
            case ($urandom_range(0, 5))
               0: c = 8'h2F;
               1: c = 8'h3A;
               2: c = 8'h40;
               3: c = 8'h47;
               4: c = 8'h60;
               default: c = 8'h67;
            endcase
         end else
            c = 8'($urandom_range(0, 255));
         send_char(c);
      end
      if ($urandom_range(0, 9) != 0)
         send_char(CHAR_CR);
   endtask

   initial begin : drain_results
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = stall_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int target;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].op == ROW_HEX_MODE) begin
            wait_idle();
            write_hex_mode(directed_rows[i].data[0]);
         end else begin
            typed_valid  = directed_rows[i].typed;
            typed_result = directed_rows[i].res;
            send_char(directed_rows[i].data);
         end
      end
      typed_valid = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_hex_mode(p == 1 || p == 2 || p == 4);
         stall_on = (p % 3) != 2;
         target = sent_items + PHASE_ITEMS;
         send_random_entry();
         wait_idle();
         while (sent_items < target)
            send_random_entry();
      end

      wait_idle();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
sv/nlep_pkg.sv
sv/nlep_front.sv
sv/nlep_cmd_queue.sv
sv/nlep_back.sv
sv/numeric_line_entry_parser.sv
verif/numeric_line_entry_parser_tb.sv
